### rtl/box_filter_3x3_zero_border_assert.svh
// Assertion macros included by the bound checker module.
// Both expect clk and rst_n in the enclosing scope.
`ifndef BOX_FILTER_3X3_ZERO_BORDER_ASSERT_SVH
`define BOX_FILTER_3X3_ZERO_BORDER_ASSERT_SVH

// same-cycle implication
`define BF3_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define BF3_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/bf3_pkg.sv
package bf3_pkg;

    localparam int MAX_WIDTH  = 1024;
    localparam int MAX_HEIGHT = 1024;
    localparam int MIN_DIM    = 2;
    localparam int PIX_W      = 8;
    localparam int KSIZE      = 3;

    localparam int ADDR_W  = $clog2(MAX_WIDTH);
    localparam int WCNT_W  = ADDR_W + 1;
    localparam int ROW_W   = $clog2(MAX_HEIGHT);
    localparam int HCNT_W  = ROW_W + 1;

    localparam int DIM_W    = 11;
    localparam int WEIGHT_W = 4;
    localparam int OP_W     = 1;
    localparam int COORD_W  = 10;
    localparam int RES_W    = 16;
    localparam int IDX_W    = 2;

    localparam int SUM_W = $clog2(KSIZE * KSIZE * (2 ** PIX_W - 1) + 1);

    // x/9 == (x * RECIP_9) >> 23 for x < 2^21; the x16 fraction scale folds
    // into the shift, so value = (sum * weight * RECIP_9) >> RECIP_SHIFT
    localparam int RECIP_SHIFT = 19;
    localparam int RECIP_9     = ((1 << (RECIP_SHIFT + 4)) + 8) / 9;
    localparam int COEF_W      = $clog2((2 ** WEIGHT_W - 1) * RECIP_9 + 1);
    localparam int PROD_W      = SUM_W + COEF_W;

    localparam int WIDTH_RESET  = 640;
    localparam int HEIGHT_RESET = 480;
    localparam int WEIGHT_RESET = 3;

    typedef enum logic [IDX_W-1:0] {
        REG_FRAME_WIDTH  = 2'd0,
        REG_FRAME_HEIGHT = 2'd1,
        REG_TAP_WEIGHT   = 2'd2
    } reg_idx_t;

    typedef enum logic [OP_W-1:0] {
        OP_PIXEL = 1'b0,
        OP_DRAIN = 1'b1
    } opcode_t;

    // item on its way from the input register into the window
    typedef struct packed {
        logic              valid;
        logic              emit;
        logic              last;
        logic              top_ok;
        logic              bot_ok;
        logic              left_ok;
        logic              right_ok;
        logic [ADDR_W-1:0] col;
        logic [PIX_W-1:0]  px;
        logic [ROW_W-1:0]  out_row;
        logic [ADDR_W-1:0] out_col;
    } s1_t;

    // masked neighborhood sum waiting for the scale stage
    typedef struct packed {
        logic              valid;
        logic              last;
        logic [SUM_W-1:0]  sum;
        logic [ROW_W-1:0]  row;
        logic [ADDR_W-1:0] col;
    } sum_t;

    function automatic logic [WCNT_W-1:0] clamp_width(input logic [DIM_W-1:0] v);
        int unsigned x;
        x = 32'(v);
        if (x < MIN_DIM)
            x = MIN_DIM;
        else if (x > MAX_WIDTH)
            x = MAX_WIDTH;
        return WCNT_W'(x);
    endfunction

    function automatic logic [HCNT_W-1:0] clamp_height(input logic [DIM_W-1:0] v);
        int unsigned x;
        x = 32'(v);
        if (x < MIN_DIM)
            x = MIN_DIM;
        else if (x > MAX_HEIGHT)
            x = MAX_HEIGHT;
        return HCNT_W'(x);
    endfunction

endpackage

### rtl/bf3_pix_if.sv
interface bf3_pix_if;
    import bf3_pkg::*;

    logic             valid;
    logic             ready;
    logic [OP_W-1:0]  opcode;
    logic [PIX_W-1:0] pixel_value;

    modport source (output valid, output opcode, output pixel_value, input ready);
    modport sink   (input valid, input opcode, input pixel_value, output ready);
endinterface

### rtl/bf3_res_if.sv
interface bf3_res_if;
    import bf3_pkg::*;

    logic               valid;
    logic               ready;
    logic [RES_W-1:0]   filtered_value;
    logic [COORD_W-1:0] out_row;
    logic [COORD_W-1:0] out_column;
    logic               frame_last;

    modport source (output valid, output filtered_value, output out_row,
                    output out_column, output frame_last, input ready);
    modport sink   (input valid, input filtered_value, input out_row,
                    input out_column, input frame_last, output ready);
endinterface

### rtl/bf3_cfg_if.sv
interface bf3_cfg_if;
    import bf3_pkg::*;

    logic             valid;
    logic             ready;
    logic [IDX_W-1:0] index;
    logic [DIM_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/bf3_ctrl.sv
module bf3_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    bf3_pix_if.sink               pixels,
    bf3_cfg_if.sink               cfg,
    input  logic                  s1_fire,
    output bf3_pkg::s1_t          s1,
    output logic                  rd_en,
    output logic [bf3_pkg::ADDR_W-1:0] rd_addr,
    output logic [bf3_pkg::COEF_W-1:0] coef
);
    import bf3_pkg::*;

    logic [DIM_W-1:0]  frame_width_reg;
    logic [DIM_W-1:0]  frame_height_reg;
    logic [COEF_W-1:0] coef_reg;

    logic [WCNT_W-1:0] act_w_reg, act_w_next;
    logic [HCNT_W-1:0] act_h_reg, act_h_next;
    logic [ADDR_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0]  in_row_reg, in_row_next;
    logic [ADDR_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0]  out_row_reg, out_row_next;
    logic              drain_reg, drain_next;
    s1_t               s1_reg, s1_next;

    logic              in_ready;
    logic              active;
    logic              latch;
    logic              emit;
    logic              last;
    logic [WCNT_W-1:0] cur_w;
    logic [HCNT_W-1:0] cur_h;
    logic [WCNT_W-1:0] in_col_inc;
    logic [HCNT_W-1:0] in_row_inc;
    logic [WCNT_W-1:0] out_col_inc;
    logic [HCNT_W-1:0] out_row_inc;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= DIM_W'(WIDTH_RESET);
            frame_height_reg <= DIM_W'(HEIGHT_RESET);
            coef_reg         <= COEF_W'(WEIGHT_RESET * RECIP_9);
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg.data;
                REG_FRAME_HEIGHT: frame_height_reg <= cfg.data;
                REG_TAP_WEIGHT:   coef_reg <= COEF_W'(32'(cfg.data[WEIGHT_W-1:0]) * RECIP_9);
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        in_ready = !s1_reg.valid || s1_fire;
        pixels.ready = in_ready;
        // a drain before the frame's end is taken and dropped
        active = pixels.valid && in_ready && (drain_reg || (pixels.opcode == OP_PIXEL));
        latch  = !drain_reg && (in_row_reg == '0) && (in_col_reg == '0);
        cur_w  = latch ? clamp_width(frame_width_reg) : act_w_reg;
        cur_h  = latch ? clamp_height(frame_height_reg) : act_h_reg;

        // output trails input by one row plus one pixel
        emit = drain_reg || (in_row_reg >= ROW_W'(2)) ||
               ((in_row_reg == ROW_W'(1)) && (in_col_reg != '0));

        in_col_inc  = WCNT_W'(in_col_reg) + WCNT_W'(1);
        in_row_inc  = HCNT_W'(in_row_reg) + HCNT_W'(1);
        out_col_inc = WCNT_W'(out_col_reg) + WCNT_W'(1);
        out_row_inc = HCNT_W'(out_row_reg) + HCNT_W'(1);
        last = (HCNT_W'(out_row_reg) == cur_h - HCNT_W'(1)) &&
               (WCNT_W'(out_col_reg) == cur_w - WCNT_W'(1));

        act_w_next   = act_w_reg;
        act_h_next   = act_h_reg;
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        drain_next   = drain_reg;

        if (active)
        begin
            act_w_next = cur_w;
            act_h_next = cur_h;
            if (in_col_inc >= cur_w)
            begin
                in_col_next = '0;
                if (!drain_reg)
                begin
                    if (in_row_inc >= cur_h)
                        drain_next = 1'b1;
                    else
                        in_row_next = in_row_inc[ROW_W-1:0];
                end
            end
            else
            begin
                in_col_next = in_col_inc[ADDR_W-1:0];
            end

            if (emit)
            begin
                if (last)
                begin
                    in_col_next  = '0;
                    in_row_next  = '0;
                    out_col_next = '0;
                    out_row_next = '0;
                    drain_next   = 1'b0;
                end
                else if (out_col_inc >= cur_w)
                begin
                    out_col_next = '0;
                    out_row_next = out_row_inc[ROW_W-1:0];
                end
                else
                begin
                    out_col_next = out_col_inc[ADDR_W-1:0];
                end
            end
        end

        s1_next = s1_reg;
        if (in_ready)
            s1_next.valid = active;
        if (active)
        begin
            s1_next.emit     = emit;
            s1_next.last     = last;
            s1_next.top_ok   = (out_row_reg != '0);
            s1_next.bot_ok   = (out_row_inc < cur_h);
            s1_next.left_ok  = (out_col_reg != '0);
            s1_next.right_ok = (out_col_inc < cur_w);
            s1_next.col      = in_col_reg;
            s1_next.px       = drain_reg ? '0 : pixels.pixel_value;
            s1_next.out_row  = out_row_reg;
            s1_next.out_col  = out_col_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            act_w_reg   <= clamp_width(DIM_W'(WIDTH_RESET));
            act_h_reg   <= clamp_height(DIM_W'(HEIGHT_RESET));
            in_col_reg  <= '0;
            in_row_reg  <= '0;
            out_col_reg <= '0;
            out_row_reg <= '0;
            drain_reg   <= 1'b0;
            s1_reg      <= '0;
        end
        else
        begin
            act_w_reg   <= act_w_next;
            act_h_reg   <= act_h_next;
            in_col_reg  <= in_col_next;
            in_row_reg  <= in_row_next;
            out_col_reg <= out_col_next;
            out_row_reg <= out_row_next;
            drain_reg   <= drain_next;
            s1_reg      <= s1_next;
        end
    end

    assign s1      = s1_reg;
    assign rd_en   = active;
    assign rd_addr = in_col_reg;
    assign coef    = coef_reg;

endmodule

### rtl/bf3_line_buf.sv
module bf3_line_buf (
    input  logic                       clk,
    input  logic                       rd_en,
    input  logic [bf3_pkg::ADDR_W-1:0] rd_addr,
    input  logic                       s1_fire,
    input  bf3_pkg::s1_t               s1,
    output logic [bf3_pkg::PIX_W-1:0]  top,
    output logic [bf3_pkg::PIX_W-1:0]  mid
);
    import bf3_pkg::*;

    logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
    logic [PIX_W-1:0] lower_mem [MAX_WIDTH];
    logic [PIX_W-1:0] upper_q_reg;
    logic [PIX_W-1:0] lower_q_reg;

    // read when the item is taken, write back when it moves into the window;
    // neighboring items of one frame always hit different columns
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            upper_q_reg <= upper_mem[rd_addr];
            lower_q_reg <= lower_mem[rd_addr];
        end
        if (s1_fire)
        begin
            upper_mem[s1.col] <= lower_q_reg;
            lower_mem[s1.col] <= s1.px;
        end
    end

    assign top = upper_q_reg;
    assign mid = lower_q_reg;

endmodule

### rtl/bf3_window.sv
module bf3_window (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      s1_fire,
    input  bf3_pkg::s1_t              s1,
    input  logic [bf3_pkg::PIX_W-1:0] top,
    input  logic [bf3_pkg::PIX_W-1:0] mid,
    input  logic                      s3_ready,
    output logic                      st2_ready,
    output bf3_pkg::sum_t             st2
);
    import bf3_pkg::*;

    logic [PIX_W-1:0] win_reg [KSIZE][KSIZE];
    logic [PIX_W-1:0] win_next [KSIZE][KSIZE];
    logic [KSIZE-1:0] row_ok;
    logic [KSIZE-1:0] col_ok;
    logic [SUM_W-1:0] sum_c;
    sum_t             st2_reg;

    always_comb
    begin
        for (int i = 0; i < KSIZE; i++)
        begin
            for (int j = 0; j < KSIZE - 1; j++)
                win_next[i][j] = win_reg[i][j+1];
        end
        win_next[0][KSIZE-1] = top;
        win_next[1][KSIZE-1] = mid;
        win_next[2][KSIZE-1] = s1.px;

        // zero border: drop taps that fall outside the frame
        row_ok = {s1.bot_ok, 1'b1, s1.top_ok};
        col_ok = {s1.right_ok, 1'b1, s1.left_ok};
        sum_c  = '0;
        for (int i = 0; i < KSIZE; i++)
        begin
            for (int j = 0; j < KSIZE; j++)
            begin
                if (row_ok[i] && col_ok[j])
                    sum_c = sum_c + SUM_W'(win_next[i][j]);
            end
        end
    end

    assign st2_ready = !st2_reg.valid || s3_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            win_reg <= '{default: '0};
            st2_reg <= '0;
        end
        else
        begin
            if (s1_fire)
                win_reg <= win_next;
            if (st2_ready)
                st2_reg.valid <= s1_fire && s1.emit;
            if (s1_fire && s1.emit)
            begin
                st2_reg.last <= s1.last;
                st2_reg.sum  <= sum_c;
                st2_reg.row  <= s1.out_row;
                st2_reg.col  <= s1.out_col;
            end
        end
    end

    assign st2 = st2_reg;

endmodule

### rtl/bf3_scale.sv
module bf3_scale (
    input  logic                       clk,
    input  logic                       rst_n,
    input  bf3_pkg::sum_t              st2,
    input  logic [bf3_pkg::COEF_W-1:0] coef,
    output logic                       s3_ready,
    bf3_res_if.source                  results
);
    import bf3_pkg::*;

    logic [PROD_W-1:0]  prod;
    logic               valid_reg;
    logic [RES_W-1:0]   value_reg;
    logic [COORD_W-1:0] row_reg;
    logic [COORD_W-1:0] col_reg;
    logic               last_reg;

    assign prod     = PROD_W'(st2.sum) * PROD_W'(coef);
    assign s3_ready = !valid_reg || results.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (s3_ready)
            valid_reg <= st2.valid;
    end

    always_ff @(posedge clk)
    begin
        if (s3_ready && st2.valid)
        begin
            value_reg <= prod[RECIP_SHIFT +: RES_W];
            row_reg   <= COORD_W'(st2.row);
            col_reg   <= COORD_W'(st2.col);
            last_reg  <= st2.last;
        end
    end

    assign results.valid          = valid_reg;
    assign results.filtered_value = value_reg;
    assign results.out_row        = row_reg;
    assign results.out_column     = col_reg;
    assign results.frame_last     = last_reg;

endmodule

### rtl/box_filter_3x3_zero_border.sv
// 3x3 box filter with zero border over a raster-order pixel stream.
// pixels: request carries opcode (pixel or drain) and an 8-bit sample.
// results: request carries floor(16 * weight * sum / 9), the row and column
// of the center pixel, and frame_last on the frame's final result.
// cfg: writes frame_width, frame_height and tap_weight by index; always ready.
// Write only while idle. Size is taken at the first pixel of each frame.
// A frame of W x H pixels yields its first result on pixel W + 2, counted
// from one; after the last pixel, W + 1 drain requests push out the rest.
// Drains before the frame's end are taken and dropped.
// Throughput: one request per clock while results.ready stays high.
// Path: the request that completes a window passes through the input register,
// the window/sum stage and the multiply into the output register.
// The line buffers are single memories indexed by column, one read and one
// write per clock.
// Reset: 640 x 480, weight 3, counters cleared; line buffer contents are not
// cleared, border masking hides unwritten entries.
// Receiver stall: the output register holds; two more requests that give results fill
// the inner stages, then pixels.ready drops until results.ready returns.
module box_filter_3x3_zero_border (
    input  logic      clk,
    input  logic      rst_n,
    bf3_pix_if.sink   pixels,
    bf3_res_if.source results,
    bf3_cfg_if.sink   cfg
);
    import bf3_pkg::*;

    s1_t               s1;
    sum_t              st2;
    logic              s1_fire;
    logic              st2_ready;
    logic              s3_ready;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [COEF_W-1:0] coef;
    logic [PIX_W-1:0]  top;
    logic [PIX_W-1:0]  mid;

    // items that give no result still shift the window, even with stage 2 full
    assign s1_fire = s1.valid && (st2_ready || !s1.emit);

    bf3_ctrl u_ctrl (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pixels),
        .cfg     (cfg),
        .s1_fire (s1_fire),
        .s1      (s1),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .coef    (coef)
    );

    bf3_line_buf u_line_buf (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .s1_fire (s1_fire),
        .s1      (s1),
        .top     (top),
        .mid     (mid)
    );

    bf3_window u_window (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_fire   (s1_fire),
        .s1        (s1),
        .top       (top),
        .mid       (mid),
        .s3_ready  (s3_ready),
        .st2_ready (st2_ready),
        .st2       (st2)
    );

    bf3_scale u_scale (
        .clk      (clk),
        .rst_n    (rst_n),
        .st2      (st2),
        .coef     (coef),
        .s3_ready (s3_ready),
        .results  (results)
    );

endmodule

### rtl/bf3_checker.sv
`include "box_filter_3x3_zero_border_assert.svh"

module bf3_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        in_valid,
    input logic                        in_ready,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [bf3_pkg::RES_W-1:0]   filtered_value,
    input logic [bf3_pkg::COORD_W-1:0] out_row,
    input logic [bf3_pkg::COORD_W-1:0] out_column,
    input logic                        frame_last
);
    import bf3_pkg::*;

    logic [31:0]        pending_reg;
    logic [COORD_W-1:0] exp_row_reg;
    logic [COORD_W:0]   exp_col_reg;
    logic               in_acc;
    logic               out_acc;

    assign in_acc  = in_valid && in_ready;
    assign out_acc = out_valid && out_ready;

    // requests taken minus results delivered, and the next expected position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
            exp_row_reg <= '0;
            exp_col_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_reg + 32'(in_acc) - 32'(out_acc);
            if (out_acc)
            begin
                if (frame_last)
                begin
                    exp_row_reg <= '0;
                    exp_col_reg <= '0;
                end
                else
                begin
                    exp_row_reg <= out_row;
                    exp_col_reg <= {1'b0, out_column} + (COORD_W + 1)'(1);
                end
            end
        end
    end

    `BF3_ASSERT_NXT(a_out_hold, out_valid && !out_ready,
        out_valid && $stable(filtered_value) && $stable(out_row) &&
        $stable(out_column) && $stable(frame_last), "result changed while stalled")

    `BF3_ASSERT_IMP(a_no_invented, out_acc, pending_reg != 32'd0,
        "result without a request behind it")

    `BF3_ASSERT_IMP(a_raster_order, out_acc,
        (out_row == exp_row_reg && {1'b0, out_column} == exp_col_reg) ||
        (out_row == exp_row_reg + COORD_W'(1) && out_column == '0 &&
         exp_col_reg != '0), "result out of raster order")

    `BF3_ASSERT_IMP(a_last_corner, out_valid && frame_last,
        out_row != '0 && out_column != '0, "frame_last on an edge pixel")

endmodule

bind box_filter_3x3_zero_border bf3_checker u_bf3_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (pixels.valid),
    .in_ready       (pixels.ready),
    .out_valid      (results.valid),
    .out_ready      (results.ready),
    .filtered_value (results.filtered_value),
    .out_row        (results.out_row),
    .out_column     (results.out_column),
    .frame_last     (results.frame_last)
);

### tb/sv/box_filter_checker.sv
`timescale 1ns / 1ps

module box_filter_checker (
    input  logic clk,
    input  logic rst_n,
    bf3_pix_if   pix,
    bf3_res_if   res,
    bf3_cfg_if   cfg,
    output int   mismatches,
    output int   results_due
);
    import bf3_pkg::*;

    typedef struct packed {
        logic [RES_W-1:0]   value;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               last;
    } filt_result_t;

    filt_result_t due[$];
    int errors = 0;

    // shadow registers and the size latched at frame start
    logic [DIM_W-1:0]    width_reg;
    logic [DIM_W-1:0]    height_reg;
    logic [WEIGHT_W-1:0] weight_reg;
    int frame_w;
    int frame_h;

    // two rows back (older) and one row back (newer), indexed by column
    logic [PIX_W-1:0] line_older [MAX_WIDTH];
    logic [PIX_W-1:0] line_newer [MAX_WIDTH];
    logic [PIX_W-1:0] win [KSIZE][KSIZE];
    int in_row;
    int in_col;
    int out_row;
    int out_col;
    bit draining;

    function automatic int clamp_dim(input logic [DIM_W-1:0] v, input int hi);
        int x;
        x = int'(v);
        if (x < MIN_DIM)
            return MIN_DIM;
        if (x > hi)
            return hi;
        return x;
    endfunction

    task automatic flag(input string msg);
        errors++;
        $display("[%0t] %s", $time, msg);
    endtask

    task automatic close_frame();
        int i;
        int j;
        for (i = 0; i < KSIZE; i++)
            for (j = 0; j < KSIZE; j++)
                win[i][j] = '0;
        in_row = 0;
        in_col = 0;
        out_row = 0;
        out_col = 0;
        draining = 1'b0;
    endtask

    task automatic clear_model();
        int i;
        width_reg = DIM_W'(WIDTH_RESET);
        height_reg = DIM_W'(HEIGHT_RESET);
        weight_reg = WEIGHT_W'(WEIGHT_RESET);
        // unwritten entries only ever land under the border mask
        for (i = 0; i < MAX_WIDTH; i++)
        begin
            line_older[i] = '0;
            line_newer[i] = '0;
        end
        close_frame();
        frame_w = clamp_dim(width_reg, MAX_WIDTH);
        frame_h = clamp_dim(height_reg, MAX_HEIGHT);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        case (idx)
            REG_FRAME_WIDTH:  width_reg = data;
            REG_FRAME_HEIGHT: height_reg = data;
            REG_TAP_WEIGHT:   weight_reg = data[WEIGHT_W-1:0];
            default: ;
        endcase
    endtask

    // one accepted pixel request: shift the window, update the line stores and
    // queue the result for the pixel one row plus one column behind
    task automatic filter_step(input opcode_t op, input logic [PIX_W-1:0] sample);
        logic [PIX_W-1:0] px;
        logic [PIX_W-1:0] top_px;
        logic [PIX_W-1:0] mid_px;
        int col;
        int sum;
        int r;
        int c;
        int i;
        int j;
        int value;
        bit emit;
        bit last;
        filt_result_t item;

        px = sample;
        if (!draining)
        begin
            if (op == OP_DRAIN)
                return;
            if (in_row == 0 && in_col == 0)
            begin
                frame_w = clamp_dim(width_reg, MAX_WIDTH);
                frame_h = clamp_dim(height_reg, MAX_HEIGHT);
            end
        end
        else
            px = '0;

        col = (in_col >= MAX_WIDTH) ? 0 : in_col;
        top_px = line_older[col];
        mid_px = line_newer[col];
        for (i = 0; i < KSIZE; i++)
        begin
            win[i][0] = win[i][1];
            win[i][1] = win[i][2];
        end
        win[0][2] = top_px;
        win[1][2] = mid_px;
        win[2][2] = px;
        line_older[col] = mid_px;
        line_newer[col] = px;

        emit = draining || in_row >= 2 || (in_row == 1 && in_col >= 1);

        in_col++;
        if (in_col >= frame_w)
        begin
            in_col = 0;
            if (!draining)
            begin
                if (in_row + 1 >= frame_h)
                    draining = 1'b1;
                else
                    in_row++;
            end
        end

        if (!emit)
            return;

        sum = 0;
        for (i = 0; i < KSIZE; i++)
        begin
            r = out_row - 1 + i;
            if (r >= 0 && r < frame_h)
            begin
                for (j = 0; j < KSIZE; j++)
                begin
                    c = out_col - 1 + j;
                    if (c >= 0 && c < frame_w)
                        sum += int'(win[i][j]);
                end
            end
        end
        value = (sum * int'(weight_reg) * 16) / 9;
        last = (out_row == frame_h - 1) && (out_col == frame_w - 1);

        item.value = RES_W'(value);
        item.row = COORD_W'(out_row);
        item.col = COORD_W'(out_col);
        item.last = last;
        due.push_back(item);

        if (last)
            close_frame();
        else
        begin
            out_col++;
            if (out_col >= frame_w)
            begin
                out_col = 0;
                out_row++;
            end
        end
    endtask

    task automatic check_result();
        filt_result_t want;
        if (due.size() == 0)
        begin
            flag($sformatf("unexpected result row %0d col %0d value %0d",
                           res.out_row, res.out_column, res.filtered_value));
            return;
        end
        want = due.pop_front();
        if (res.filtered_value !== want.value)
            flag($sformatf("filtered_value at row %0d col %0d: got %0d expected %0d",
                           want.row, want.col, res.filtered_value, want.value));
        if (res.out_row !== want.row)
            flag($sformatf("out_row: got %0d expected %0d (col %0d)",
                           res.out_row, want.row, want.col));
        if (res.out_column !== want.col)
            flag($sformatf("out_column: got %0d expected %0d (row %0d)",
                           res.out_column, want.col, want.row));
        if (res.frame_last !== want.last)
            flag($sformatf("frame_last at row %0d col %0d: got %0b expected %0b",
                           want.row, want.col, res.frame_last, want.last));
    endtask

    // results are checked before the same-edge request is predicted; a result
    // can never stem from a request taken at the same edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_model();
            due.delete();
            results_due <= 0;
            mismatches <= errors;
        end
        else
        begin
            if (res.valid && res.ready)
                check_result();
            if (cfg.valid && cfg.ready)
                write_reg(cfg.index, cfg.data);
            if (pix.valid && pix.ready)
                filter_step(opcode_t'(pix.opcode), pix.pixel_value);
            results_due <= due.size();
            mismatches <= errors;
        end
    end

endmodule

### tb/sv/tb_box_filter_3x3_zero_border.sv
`timescale 1ns / 1ps

module tb_box_filter_3x3_zero_border;
    import bf3_pkg::*;

    localparam int SETTLE_CYCLES = 10;
    localparam int RANDOM_ITEMS  = 650;
    localparam int WIDE_COLS     = 200;
    localparam int TALL_ROWS     = 200;
    localparam int STALL_AT      = 600;
    localparam int STALL_CYCLES  = 300;
    localparam int STUCK_LIMIT   = 3000;
    // index with no register behind it
    localparam logic [IDX_W-1:0] SPARE_REG = 2'd3;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    bf3_pix_if pix_bus ();
    bf3_res_if res_bus ();
    bf3_cfg_if cfg_bus ();

    int mismatches;
    int results_due;
    bit send_burst;
    int counted;

    box_filter_3x3_zero_border dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pix_bus),
        .results (res_bus),
        .cfg     (cfg_bus)
    );

    box_filter_checker u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .pix         (pix_bus),
        .res         (res_bus),
        .cfg         (cfg_bus),
        .mismatches  (mismatches),
        .results_due (results_due)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    function automatic logic [PIX_W-1:0] pick_pixel(input bit extremes);
        if (extremes)
            return ($urandom_range(0, 1) != 0) ? '1 : '0;
        return PIX_W'($urandom_range(0, 255));
    endfunction

    // weight in the low bits, junk above them
    function automatic logic [DIM_W-1:0] weight_word(input int w);
        logic [DIM_W-1:0] word;
        word = DIM_W'($urandom_range(0, 2047));
        word[WEIGHT_W-1:0] = WEIGHT_W'(w);
        return word;
    endfunction

    // a size of 2 is sometimes written as 0 or 1, which clamps up to 2
    function automatic logic [DIM_W-1:0] dim_word(input int d);
        if (d == MIN_DIM && $urandom_range(0, 1) != 0)
            return DIM_W'($urandom_range(0, 1));
        return DIM_W'(d);
    endfunction

    task automatic send_request(input opcode_t op, input logic [PIX_W-1:0] px);
        int gap;
        gap = send_burst ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            pix_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        pix_bus.valid <= 1'b1;
        pix_bus.opcode <= op;
        pix_bus.pixel_value <= px;
        @(posedge clk);
        while (!pix_bus.ready) @(posedge clk);
    endtask

    // leaves valid high; the caller lowers it after the last write
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data <= data;
        @(posedge clk);
        while (!cfg_bus.ready) @(posedge clk);
    endtask

    task automatic wait_idle();
        pix_bus.valid <= 1'b0;
        @(posedge clk);
        while (results_due != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic run_frame(input int w, input int h, input bit extremes, input bit noisy);
        int n;
        for (n = 0; n < w * h; n++)
        begin
            // drain request inside the frame: taken and dropped
            if (noisy && $urandom_range(0, 24) == 0)
                send_request(OP_DRAIN, pick_pixel(1'b0));
            send_request(OP_PIXEL, pick_pixel(extremes));
            counted++;
        end
        // a pixel request here still acts as a drain step
        for (n = 0; n <= w; n++)
        begin
            send_request(opcode_t'(($urandom_range(0, 6) == 0) ? OP_PIXEL : OP_DRAIN),
                         pick_pixel(1'b0));
            counted++;
        end
        if (noisy && $urandom_range(0, 9) == 0)
            send_request(OP_DRAIN, pick_pixel(1'b0));
    endtask

    initial
    begin : stimulus
        int n;
        int w;
        int h;
        bit first;

        pix_bus.valid = 1'b0;
        pix_bus.opcode = OP_PIXEL;
        pix_bus.pixel_value = '0;
        cfg_bus.valid = 1'b0;
        cfg_bus.index = REG_FRAME_WIDTH;
        cfg_bus.data = '0;
        send_burst = 1'b0;
        counted = 0;
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // 3x3 frame at full scale and the largest weight
        write_reg(REG_TAP_WEIGHT, weight_word(15));
        write_reg(REG_FRAME_WIDTH, DIM_W'(3));
        write_reg(REG_FRAME_HEIGHT, DIM_W'(3));
        write_reg(SPARE_REG, '1);
        cfg_bus.valid <= 1'b0;
        send_request(OP_DRAIN, 8'hA5);
        for (n = 0; n < 9; n++)
        begin
            send_request(OP_PIXEL, '1);
            if (n == 4)
                send_request(OP_DRAIN, '0);
        end
        for (n = 0; n < 4; n++)
            send_request(OP_DRAIN, '0);

        // 2x2 frame; weight changes inside the frame take effect at once,
        // size changes wait for the next frame
        wait_idle();
        write_reg(REG_TAP_WEIGHT, weight_word(0));
        write_reg(REG_FRAME_WIDTH, DIM_W'(2));
        write_reg(REG_FRAME_HEIGHT, DIM_W'(2));
        cfg_bus.valid <= 1'b0;
        send_request(OP_PIXEL, '0);
        send_request(OP_PIXEL, '1);
        send_request(OP_PIXEL, '1);
        send_request(OP_PIXEL, '0);
        wait_idle();
        write_reg(REG_TAP_WEIGHT, weight_word(15));
        write_reg(REG_FRAME_WIDTH, '1);
        write_reg(REG_FRAME_HEIGHT, DIM_W'(1));
        cfg_bus.valid <= 1'b0;
        send_request(OP_DRAIN, '1);
        send_request(OP_PIXEL, '1);
        send_request(OP_DRAIN, '0);

        // wide frame; a height of 1 clamps to 2 rows
        wait_idle();
        write_reg(REG_FRAME_WIDTH, DIM_W'(WIDE_COLS));
        write_reg(REG_TAP_WEIGHT, weight_word($urandom_range(0, 15)));
        cfg_bus.valid <= 1'b0;
        run_frame(WIDE_COLS, MIN_DIM, 1'b0, 1'b1);

        // tall frame
        wait_idle();
        write_reg(REG_FRAME_WIDTH, DIM_W'(1));
        write_reg(REG_FRAME_HEIGHT, DIM_W'(TALL_ROWS));
        write_reg(REG_TAP_WEIGHT, weight_word($urandom_range(0, 15)));
        cfg_bus.valid <= 1'b0;
        run_frame(MIN_DIM, TALL_ROWS, 1'b0, 1'b1);

        // small frames, random sizes and content
        first = 1'b1;
        w = MIN_DIM;
        h = MIN_DIM;
        counted = 0;
        while (counted < RANDOM_ITEMS)
        begin
            wait_idle();
            if (first || $urandom_range(0, 1) != 0)
            begin
                w = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 64)
                                                : $urandom_range(MIN_DIM, 12);
                write_reg(REG_FRAME_WIDTH, dim_word(w));
            end
            if (first || $urandom_range(0, 1) != 0)
            begin
                h = $urandom_range(MIN_DIM, 8);
                write_reg(REG_FRAME_HEIGHT, dim_word(h));
            end
            if (first || $urandom_range(0, 1) != 0)
            begin
                if ($urandom_range(0, 4) == 0)
                    write_reg(REG_TAP_WEIGHT, weight_word(($urandom_range(0, 1) != 0) ? 15 : 0));
                else
                    write_reg(REG_TAP_WEIGHT, weight_word($urandom_range(0, 15)));
            end
            first = 1'b0;
            cfg_bus.valid <= 1'b0;
            send_burst = ($urandom_range(0, 3) == 0);
            run_frame(w, h, $urandom_range(0, 4) == 0, 1'b1);
        end

        wait_idle();
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin : result_sink
        int gap;
        int taken;
        bit no_idle;

        res_bus.ready = 1'b0;
        taken = 0;
        no_idle = 1'b0;
        while (!rst_n) @(posedge clk);
        forever
        begin
            gap = no_idle ? 0 : $urandom_range(0, 4);
            // one long hold-off so the block backs up into the pixel side
            if (taken == STALL_AT)
                gap = STALL_CYCLES;
            if (gap > 0)
            begin
                res_bus.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_bus.ready <= 1'b1;
            @(posedge clk);
            while (!res_bus.valid) @(posedge clk);
            taken++;
            if (taken % 32 == 0)
                no_idle = ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STUCK_LIMIT)
        begin
            @(posedge clk);
            if ((pix_bus.valid && pix_bus.ready) || (res_bus.valid && res_bus.ready) ||
                (cfg_bus.valid && cfg_bus.ready) || !rst_n)
                stuck = 0;
            else
                stuck++;
        end
        $display("simulation failed");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/bf3_pkg.sv
rtl/bf3_pix_if.sv
rtl/bf3_res_if.sv
rtl/bf3_cfg_if.sv
rtl/bf3_ctrl.sv
rtl/bf3_line_buf.sv
rtl/bf3_window.sv
rtl/bf3_scale.sv
rtl/box_filter_3x3_zero_border.sv
rtl/bf3_checker.sv
tb/sv/box_filter_checker.sv
tb/sv/tb_box_filter_3x3_zero_border.sv
